[sv/assert_macros.svh]
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

[sv/bdpc_pkg.sv]
// Shared types and constants of the button debounce and press classifier.
`default_nettype none

package bdpc_pkg;

	// Width of every threshold register and of the hold query.
	localparam int unsigned THR_W = 16;
	// Width of the configuration register index.
	localparam int unsigned IDX_W = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SHORT_MIN = 3'd1;
	localparam logic [IDX_W-1:0] REG_SHORT_MAX = 3'd2;
	localparam logic [IDX_W-1:0] REG_LONG_MIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_REPEAT    = 3'd4;

	// Reset values of the thresholds, one tick per millisecond.
	localparam logic [THR_W-1:0] RST_DEBOUNCE  = 16'd50;
	localparam logic [THR_W-1:0] RST_SHORT_MIN = 16'd50;
	localparam logic [THR_W-1:0] RST_SHORT_MAX = 16'd1000;
	localparam logic [THR_W-1:0] RST_LONG_MIN  = 16'd1000;
	localparam logic [THR_W-1:0] RST_REPEAT    = 16'd200;

	// Threshold set handed from the register file to the datapath.
	typedef struct packed {
		logic [THR_W-1:0] debounce;
		logic [THR_W-1:0] short_min;
		logic [THR_W-1:0] short_max;
		logic [THR_W-1:0] long_min;
		logic [THR_W-1:0] repeat_gap;
	} cfg_t;

endpackage

`default_nettype wire

[sv/bdpc_cfg.sv]
// Configuration register file holding the debounce and press thresholds.
`default_nettype none

module bdpc_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bdpc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [bdpc_pkg::THR_W-1:0]  cfg_data,
	output bdpc_pkg::cfg_t                   cfg
);
	import bdpc_pkg::*;

	cfg_t cfg_q;

	// The register file takes a write request in every cycle.
	assign cfg_ready = 1'b1;

	// Decode the index; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce   <= RST_DEBOUNCE;
			cfg_q.short_min  <= RST_SHORT_MIN;
			cfg_q.short_max  <= RST_SHORT_MAX;
			cfg_q.long_min   <= RST_LONG_MIN;
			cfg_q.repeat_gap <= RST_REPEAT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEBOUNCE:  cfg_q.debounce   <= cfg_data;
				REG_SHORT_MIN: cfg_q.short_min  <= cfg_data;
				REG_SHORT_MAX: cfg_q.short_max  <= cfg_data;
				REG_LONG_MIN:  cfg_q.long_min   <= cfg_data;
				REG_REPEAT:    cfg_q.repeat_gap <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[sv/bdpc_core.sv]
// Debounce state, saturating tick counters and press classification.
`default_nettype none

module bdpc_core #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        take,
	input  wire logic                        raw_s1,
	input  wire logic [bdpc_pkg::THR_W-1:0]  query_s1,
	input  wire bdpc_pkg::cfg_t              cfg,
	output logic                             is_down_s2,
	output logic                             short_s2,
	output logic                             long_s2,
	output logic                             held_s2
);
	import bdpc_pkg::*;

	// Common compare width covering both counters and thresholds.
	localparam int unsigned CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	logic                  prev_raw_q;
	logic                  down_q;
	logic [COUNT_BITS-1:0] stable_q;
	logic [COUNT_BITS-1:0] hold_q;
	logic [COUNT_BITS-1:0] since_q;

	logic                  down_n;
	logic [COUNT_BITS-1:0] stable_n;
	logic [COUNT_BITS-1:0] hold_n;
	logic [COUNT_BITS-1:0] since_n;
	logic                  short_n;
	logic                  long_n;
	logic                  held_n;
	logic                  accept;
	logic [CMP_W-1:0]      stable_x;
	logic [CMP_W-1:0]      hold_x;
	logic [CMP_W-1:0]      since_x;

	// Advance all counters, then apply edge restart and debounced change.
	always_comb begin
		stable_n = (stable_q == '1) ? stable_q : stable_q + 1'b1;
		hold_n   = (hold_q == '1) ? hold_q : hold_q + 1'b1;
		since_n  = (since_q == '1) ? since_q : since_q + 1'b1;
		short_n  = 1'b0;
		long_n   = 1'b0;
		down_n   = down_q;

		// A raw edge restarts the stability count.
		if (raw_s1 != prev_raw_q) begin
			stable_n = '0;
		end

		stable_x = CMP_W'(stable_n);
		hold_x   = CMP_W'(hold_n);
		since_x  = CMP_W'(since_n);
		accept   = (raw_s1 != down_q) && (stable_x > CMP_W'(cfg.debounce));

		// An accepted press restarts the hold count; a release is classified.
		if (accept) begin
			stable_n = '0;
			down_n   = raw_s1;
			if (raw_s1) begin
				hold_n = '0;
			end else if ((hold_x < CMP_W'(cfg.short_max)) &&
			             (hold_x > CMP_W'(cfg.short_min))) begin
				if (since_x > CMP_W'(cfg.repeat_gap)) begin
					since_n = '0;
					short_n = 1'b1;
				end
			end else if (hold_x > CMP_W'(cfg.long_min)) begin
				long_n = 1'b1;
			end
		end

		held_n = down_n && (CMP_W'(hold_n) > CMP_W'(query_s1));
	end

	// State registers update once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= 1'b0;
			down_q     <= 1'b0;
			stable_q   <= '0;
			hold_q     <= '0;
			since_q    <= '0;
		end else if (take) begin
			prev_raw_q <= raw_s1;
			down_q     <= down_n;
			stable_q   <= stable_n;
			hold_q     <= hold_n;
			since_q    <= since_n;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (take) begin
			is_down_s2 <= down_n;
			short_s2   <= short_n;
			long_s2    <= long_n;
			held_s2    <= held_n;
		end
	end

endmodule

`default_nettype wire

[sv/button_debounce_press_classifier.sv]
// Top level of the button debouncer with short and long press detection.
// Takes one tick sample per cycle and returns one result per sample. A sample is held in the
// input register, then passes through the state update into the result register. The state
// update is a loop of saturating increments and threshold compares, so samples stream at one
// per clock when the output is not stalled. The user must write thresholds through the
// configuration port only while no sample is in flight; the block does not enforce this.
`default_nettype none

module button_debounce_press_classifier #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        raw_pressed,
	input  wire logic [bdpc_pkg::THR_W-1:0]  hold_query_ticks,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             is_down,
	output logic                             short_press,
	output logic                             long_press,
	output logic                             held_over,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bdpc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [bdpc_pkg::THR_W-1:0]  cfg_data
);
	import bdpc_pkg::*;

	cfg_t             cfg;
	logic             valid_s1;
	logic             raw_s1;
	logic [THR_W-1:0] query_s1;
	logic             valid_s2;
	logic             adv_s2;
	logic             take;
	logic             load_s1;

	// The result stage can load when empty or when its request leaves.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign take     = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	// Input register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			raw_s1   <= raw_pressed;
			query_s1 <= hold_query_ticks;
		end
	end

	// Result register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;

	bdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdpc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.raw_s1     (raw_s1),
		.query_s1   (query_s1),
		.cfg        (cfg),
		.is_down_s2 (is_down),
		.short_s2   (short_press),
		.long_s2    (long_press),
		.held_s2    (held_over)
	);

endmodule

`default_nettype wire

[sv/bdpc_checker.sv]
// Port-level checker for the button debounce and press classifier, with its bind.
`default_nettype none

`include "assert_macros.svh"

module bdpc_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic                        is_down,
	input  wire logic                        short_press,
	input  wire logic                        long_press,
	input  wire logic                        held_over
);

	// A release is classified as at most one kind of press.
	`ASSERT_NOW(a_one_event, out_valid, !(short_press && long_press))

	// A press event comes only with the button released.
	`ASSERT_NOW(a_event_released, out_valid && (short_press || long_press), !is_down)

	// The hold flag is only raised while the button is down.
	`ASSERT_NOW(a_held_down, out_valid && held_over, is_down)

	// A stalled result stays offered.
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(is_down))

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);

`default_nettype wire

[verif/tb_button_debounce_press_classifier.sv]
// Self-checking testbench for the button debouncer with short and long press classification.
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier;
	import bdpc_pkg::*;

	localparam int unsigned CNT_W = 16;

	// One tick request as queued for the driver, with the idle cycles that come before it.
	typedef struct {
		logic             raw;
		logic [THR_W-1:0] query;
		int unsigned      gap;
	} tick_req_t;

	// The four result fields of one tick.
	typedef struct packed {
		logic is_down;
		logic short_press;
		logic long_press;
		logic held_over;
	} press_res_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             raw_pressed = 1'b0;
	logic [THR_W-1:0] hold_query_ticks = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             is_down;
	logic             short_press;
	logic             long_press;
	logic             held_over;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;

	// Stimulus and expectation stores.
	tick_req_t  tick_pend[$];
	press_res_t exp_press[$];
	int         n_open = 0;
	int         n_gen = 0;
	int         n_fail = 0;
	bit         tx_calm = 1'b0;
	bit         rx_quiet = 1'b0;

	// Handshake flags, set at the rising edge and read at the falling edge.
	logic tick_taken = 1'b0;
	logic res_taken = 1'b0;

	// Shadow of the threshold registers and of the classifier state.
	cfg_t             thr;
	logic             st_prev;
	logic             st_down;
	logic [CNT_W-1:0] cnt_stable;
	logic [CNT_W-1:0] cnt_hold;
	logic [CNT_W-1:0] cnt_since;

	// Driver and receiver bookkeeping.
	tick_req_t   next_tick;
	bit          have_next = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int          n_res = 0;

	button_debounce_press_classifier #(
		.COUNT_BITS(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_pressed(raw_pressed),
		.hold_query_ticks(hold_query_ticks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_down(is_down),
		.short_press(short_press),
		.long_press(long_press),
		.held_over(held_over),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	// Advances the shadow state by one tick and returns the result that tick produces.
	function automatic press_res_t tick_classify(input logic raw, input logic [THR_W-1:0] query);
		press_res_t       r;
		logic [CNT_W-1:0] h;
		r = '0;
		cnt_stable = sat_inc(cnt_stable);
		cnt_hold = sat_inc(cnt_hold);
		cnt_since = sat_inc(cnt_since);
		if (raw != st_prev)
			cnt_stable = '0;
		st_prev = raw;
		// A change is taken only once the raw level has been stable long enough.
		if (raw != st_down && cnt_stable > thr.debounce) begin
			cnt_stable = '0;
			if (raw) begin
				cnt_hold = '0;
			end else begin
				h = cnt_hold;
				if (h < thr.short_max && h > thr.short_min) begin
					if (cnt_since > thr.repeat_gap) begin
						cnt_since = '0;
						r.short_press = 1'b1;
					end
				end else if (h > thr.long_min) begin
					r.long_press = 1'b1;
				end
			end
			st_down = raw;
		end
		r.is_down = st_down;
		r.held_over = st_down && (cnt_hold > query);
		return r;
	endfunction

	// Tracks register writes and accepted tick requests, and queues the expected results.
	always @(posedge clk) begin
		if (!arst_n) begin
			thr.debounce = RST_DEBOUNCE;
			thr.short_min = RST_SHORT_MIN;
			thr.short_max = RST_SHORT_MAX;
			thr.long_min = RST_LONG_MIN;
			thr.repeat_gap = RST_REPEAT;
			st_prev = 1'b0;
			st_down = 1'b0;
			cnt_stable = '0;
			cnt_hold = '0;
			cnt_since = '0;
			tick_taken <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE:  thr.debounce = cfg_data;
					REG_SHORT_MIN: thr.short_min = cfg_data;
					REG_SHORT_MAX: thr.short_max = cfg_data;
					REG_LONG_MIN:  thr.long_min = cfg_data;
					REG_REPEAT:    thr.repeat_gap = cfg_data;
					default: ;
				endcase
			end
			tick_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				exp_press.push_back(tick_classify(raw_pressed, hold_query_ticks));
				n_open--;
			end
		end
	end

	// Driver: offers queued tick requests, idling for each one's gap before it.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !tick_taken)) begin
			if (!have_next && tick_pend.size() != 0) begin
				next_tick = tick_pend.pop_front();
				have_next = 1'b1;
				gap_left = next_tick.gap;
			end
			if (have_next && gap_left == 0) begin
				raw_pressed <= next_tick.raw;
				hold_query_ticks <= next_tick.query;
				in_valid <= 1'b1;
				have_next = 1'b0;
			end else begin
				if (gap_left != 0)
					gap_left--;
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: a random hold-off after each result outside quiet phases, and two long ones to back up the block.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (res_taken) begin
				n_res++;
				if (n_res == 150 || n_res == 500)
					stall_left = 240;
				else if (rx_quiet)
					stall_left = 0;
				else
					stall_left = $urandom_range(0, 16);
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		press_res_t want;
		if (!arst_n) begin
			res_taken <= 1'b0;
		end else begin
			res_taken <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (exp_press.size() == 0) begin
					$error("result arrived with no pending tick: is_down=%0b short=%0b long=%0b held=%0b",
						is_down, short_press, long_press, held_over);
					n_fail++;
				end else begin
					want = exp_press.pop_front();
					if (is_down !== want.is_down) begin
						$error("is_down mismatch: expected %0b, actual %0b", want.is_down, is_down);
						n_fail++;
					end
					if (short_press !== want.short_press) begin
						$error("short_press mismatch: expected %0b, actual %0b",
							want.short_press, short_press);
						n_fail++;
					end
					if (long_press !== want.long_press) begin
						$error("long_press mismatch: expected %0b, actual %0b",
							want.long_press, long_press);
						n_fail++;
					end
					if (held_over !== want.held_over) begin
						$error("held_over mismatch: expected %0b, actual %0b", want.held_over, held_over);
						n_fail++;
					end
				end
			end
		end
	end

	function automatic logic [THR_W-1:0] pick_query();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return '1 - 1'b1;
			3: return THR_W'($urandom);
			default: return THR_W'($urandom_range(0, 48));
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		return tx_calm ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic push_tick(input logic raw, input logic [THR_W-1:0] query, input int unsigned gap);
		tick_req_t t;
		t.raw = raw;
		t.query = query;
		t.gap = gap;
		tick_pend.push_back(t);
		n_open++;
		n_gen++;
	endtask

	task automatic push_run(input logic raw, input int len);
		for (int i = 0; i < len; i++)
			push_tick(raw, pick_query(), pick_gap());
	endtask

	// Contact bounce: a few short runs of alternating level.
	task automatic push_bounce(input logic first, input int db);
		logic lvl;
		int   k;
		lvl = first;
		k = $urandom_range(1, 4);
		for (int i = 0; i < k; i++) begin
			push_run(lvl, $urandom_range(1, db + 1));
			lvl = !lvl;
		end
	endtask

	// One well-formed press and release, sometimes with bounce on either edge.
	task automatic push_press(input int db, input int span);
		if ($urandom_range(0, 3) == 0)
			push_bounce(1'b1, db);
		push_run(1'b1, db + 1 + $urandom_range(0, span));
		if ($urandom_range(0, 3) == 0)
			push_bounce(1'b0, db);
		push_run(1'b0, db + 1 + $urandom_range(0, span));
	endtask

	// A short burst of random raw levels.
	task automatic push_noise();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			push_tick(1'($urandom_range(0, 1)), pick_query(), pick_gap());
	endtask

	// Issues one register write request; returns at the falling edge after it was taken.
	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [THR_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_thresholds(input logic [THR_W-1:0] dbt, smin, smax, lmin, rep);
		reg_write(REG_DEBOUNCE, dbt);
		reg_write(REG_SHORT_MIN, smin);
		reg_write(REG_SHORT_MAX, smax);
		reg_write(REG_LONG_MIN, lmin);
		reg_write(REG_REPEAT, rep);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued tick has been answered, then lets the pipeline settle.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (n_open != 0 || exp_press.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// One random phase under a given threshold set.
	task automatic run_random(input logic [THR_W-1:0] dbt, smin, smax, lmin, rep,
			input int target, input bit quiet);
		int db;
		int span;
		int start;
		set_thresholds(dbt, smin, smax, lmin, rep);
		@(posedge clk);
		rx_quiet = quiet;
		db = (dbt > 8) ? 8 : int'(dbt);
		span = (smax > lmin) ? int'(smax) : int'(lmin);
		span = (span > 57) ? 60 : span + 3;
		start = n_gen;
		while (n_gen - start < target) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0)
				push_noise();
			else
				push_press(db, span);
		end
		wait_quiet();
	endtask

	initial begin
		logic [IDX_W-1:0] spare_idx;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset thresholds: a raw edge on every tick, queries at both ends.
		@(posedge clk);
		push_tick(1'b1, '1, pick_gap());
		push_tick(1'b0, '0, pick_gap());
		push_tick(1'b1, '0, pick_gap());
		push_tick(1'b0, '1, pick_gap());
		wait_quiet();

		// Tight thresholds: short press, short press inside the repeat gap, glitch, long press.
		set_thresholds(16'd1, 16'd1, 16'd6, 16'd6, 16'd8);
		@(posedge clk);
		push_run(1'b1, 4);
		push_run(1'b0, 3);
		push_run(1'b1, 4);
		push_run(1'b0, 3);
		push_tick(1'b1, '0, 0);
		push_tick(1'b0, '1, 0);
		push_tick(1'b1, '1, pick_gap());
		push_run(1'b1, 9);
		push_run(1'b0, 3);
		wait_quiet();

		// Random phases over several threshold sets, extremes among them.
		run_random(16'd2, 16'd3, 16'd12, 16'd15, 16'd20, 140, 1'b0);
		run_random(16'd0, 16'd0, 16'd8, 16'd8, 16'd0, 130, 1'b0);
		run_random(16'd4, 16'd5, 16'd25, 16'd10, 16'd40, 140, 1'b1);
		run_random(THR_W'($urandom_range(0, 6)), THR_W'($urandom_range(0, 10)),
			THR_W'($urandom_range(0, 30)), THR_W'($urandom_range(0, 30)),
			THR_W'($urandom_range(0, 50)), 120, 1'b0);
		run_random(THR_W'($urandom_range(0, 6)), THR_W'($urandom_range(0, 10)),
			THR_W'($urandom_range(0, 30)), THR_W'($urandom_range(0, 30)),
			THR_W'($urandom_range(0, 50)), 120, 1'b0);
		run_random('0, '0, '0, '0, '0, 100, 1'b0);
		run_random('1, '1, '1, '1, '1, 40, 1'b0);

		// Writes to indexes past the last register must leave every threshold alone.
		for (int k = int'(REG_REPEAT) + 1; k < (1 << IDX_W); k++) begin
			spare_idx = k[IDX_W-1:0];
			reg_write(spare_idx, THR_W'($urandom));
		end
		run_random(16'd1, '0, '1, '1, '0, 110, 1'b0);

		if (n_fail == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
